### rtl/cbs_pkg.sv
// Types, constants and state codes for the centroid bounding sphere core.
// No dependencies.
package cbs_pkg;
	localparam int unsigned COORD_W = 24;
	localparam int unsigned RADIUS_W = 25;
	localparam int unsigned SUM_W = 41;
	localparam int unsigned SQ_W = 52;
	localparam int unsigned CNT_W = 17;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
		logic last_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic [RADIUS_W-1:0] radius;
		logic overflowed;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_DX,
		ST_DY,
		ST_DZ,
		ST_ACC,
		ST_SQRT,
		ST_DONE
	} state_t;
endpackage

### rtl/cbs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module cbs_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/centroid_bounding_sphere_core.sv
// Top level of the centroid bounding sphere core: loader, divider, distance pass, sqrt.
// Depends on cbs_pkg and cbs_ram.
//
// channel | signals                  | handshake
// vertex  | start, busy, in_item     | taken when start && !busy
// result  | done, out_item           | one cycle strobe, no stall
//
// A plain vertex is stored and summed while idle. The last vertex starts the bit-serial
// divider (one quotient bit per cycle, three axes), then a read state and the DX, DY, DZ
// and ACC states per stored vertex for the distance pass through one shared 26x26
// multiplier, then the bit-pair square root and a DONE state to emit.
// No clearing pass after reset.
module centroid_bounding_sphere_core #(
	parameter int unsigned MAX_VERTICES = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cbs_pkg::in_item_t in_item,
	output logic busy,
	output logic done,
	output cbs_pkg::out_item_t out_item
);
	localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned SW = cbs_pkg::SUM_W;
	localparam int unsigned CW = cbs_pkg::CNT_W;
	localparam int unsigned DW = 26;
	localparam int unsigned QW = cbs_pkg::SQ_W;
	localparam int unsigned RADIUS_W_L = cbs_pkg::RADIUS_W;

	cbs_pkg::state_t state_q, state_d;
	logic signed [SW-1:0] sum_q [3];
	logic [CW-1:0] count_q;
	logic drop_q;
	logic [1:0] axis_q;
	logic [5:0] step_q;
	logic [SW-1:0] quo_q;
	logic [CW:0] rem_q;
	logic signed [cbs_pkg::COORD_W-1:0] cen_q [3];
	logic [CW-1:0] rd_idx_q;
	logic [QW-1:0] acc_q, max_q;
	logic [QW-1:0] sq_n_q, sq_res_q;
	logic [4:0] sq_k_q;
	cbs_pkg::out_item_t out_q;
	logic done_q;

	logic take, store_ok;
	logic [cbs_pkg::COORD_W-1:0] rx, ry, rz;

	assign take = start && !busy;
	assign store_ok = count_q < CW'(MAX_VERTICES);

	cbs_ram #(.WIDTH(cbs_pkg::COORD_W), .DEPTH(MAX_VERTICES)) u_x (
		.clk(clk), .we(take && store_ok), .waddr(count_q[AW-1:0]),
		.wdata(in_item.x_coord), .raddr(rd_idx_q[AW-1:0]), .rdata(rx));
	cbs_ram #(.WIDTH(cbs_pkg::COORD_W), .DEPTH(MAX_VERTICES)) u_y (
		.clk(clk), .we(take && store_ok), .waddr(count_q[AW-1:0]),
		.wdata(in_item.y_coord), .raddr(rd_idx_q[AW-1:0]), .rdata(ry));
	cbs_ram #(.WIDTH(cbs_pkg::COORD_W), .DEPTH(MAX_VERTICES)) u_z (
		.clk(clk), .we(take && store_ok), .waddr(count_q[AW-1:0]),
		.wdata(in_item.z_coord), .raddr(rd_idx_q[AW-1:0]), .rdata(rz));

	// divider operands: magnitude of selected sum
	logic signed [SW-1:0] div_sum;
	logic [SW-1:0] div_mag;
	logic [CW:0] rem_sh, rem_sub;
	logic rem_ge;
	logic [SW-1:0] quo_sh;
	logic [SW-1:0] quo_res;
	assign div_sum = sum_q[axis_q];
	assign div_mag = div_sum[SW-1] ? SW'(-div_sum) : div_sum;
	assign rem_sh = {rem_q[CW-1:0], div_mag[SW-1-step_q]};
	assign rem_ge = rem_sh >= {1'b0, count_q};
	assign rem_sub = rem_sh - {1'b0, count_q};
	assign quo_sh = {quo_q[SW-2:0], rem_ge};
	assign quo_res = div_sum[SW-1] ? SW'(-quo_sh) : quo_sh;

	// shared multiplier
	logic signed [cbs_pkg::COORD_W-1:0] mul_src;
	logic signed [DW-1:0] mul_d;
	logic signed [2*DW-1:0] mul_p;
	always_comb begin
		unique case (axis_q)
			2'd0: mul_src = rx;
			2'd1: mul_src = ry;
			default: mul_src = rz;
		endcase
	end
	assign mul_d = DW'(mul_src) - DW'(cen_q[axis_q]);
	assign mul_p = mul_d * mul_d;

	// square root step
	logic [QW-1:0] sq_bit, sq_try;
	assign sq_bit = QW'(1) << {sq_k_q, 1'b0};
	assign sq_try = sq_res_q + sq_bit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbs_pkg::ST_IDLE: if (take && in_item.last_vertex) state_d = cbs_pkg::ST_DIV;
			cbs_pkg::ST_DIV: if (step_q == 6'(SW-1) && axis_q == 2'd2) state_d =
				(count_q == '0) ? cbs_pkg::ST_SQRT : cbs_pkg::ST_RD;
			cbs_pkg::ST_RD: state_d = cbs_pkg::ST_DX;
			cbs_pkg::ST_DX: state_d = cbs_pkg::ST_DY;
			cbs_pkg::ST_DY: state_d = cbs_pkg::ST_DZ;
			cbs_pkg::ST_DZ: state_d = cbs_pkg::ST_ACC;
			cbs_pkg::ST_ACC: state_d = (rd_idx_q == count_q) ? cbs_pkg::ST_SQRT
				: cbs_pkg::ST_DX;
			cbs_pkg::ST_SQRT: if (sq_k_q == '0) state_d = cbs_pkg::ST_DONE;
			cbs_pkg::ST_DONE: state_d = cbs_pkg::ST_IDLE;
			default: state_d = cbs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbs_pkg::ST_IDLE;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			count_q <= '0;
			drop_q <= 1'b0;
			max_q <= '0;
			done_q <= 1'b0;
			axis_q <= '0;
			step_q <= '0;
			rd_idx_q <= '0;
			sq_k_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			unique case (state_q)
				cbs_pkg::ST_IDLE: begin
					if (take) begin
						if (store_ok) begin
							sum_q[0] <= sum_q[0] + SW'(in_item.x_coord);
							sum_q[1] <= sum_q[1] + SW'(in_item.y_coord);
							sum_q[2] <= sum_q[2] + SW'(in_item.z_coord);
							count_q <= count_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
					axis_q <= '0;
					step_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
					rd_idx_q <= '0;
				end
				cbs_pkg::ST_DIV: begin
					if (step_q == 6'(SW-1)) begin
						cen_q[axis_q] <= quo_res[cbs_pkg::COORD_W-1:0];
						step_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					end else begin
						step_q <= step_q + 6'd1;
						rem_q <= rem_ge ? rem_sub : rem_sh;
						quo_q <= quo_sh;
					end
					sq_k_q <= 5'd25;
				end
				cbs_pkg::ST_RD: begin
					axis_q <= '0;
				end
				cbs_pkg::ST_DX: begin
					acc_q <= QW'(mul_p);
					axis_q <= 2'd1;
				end
				cbs_pkg::ST_DY: begin
					acc_q <= acc_q + QW'(mul_p);
					axis_q <= 2'd2;
				end
				cbs_pkg::ST_DZ: begin
					acc_q <= acc_q + QW'(mul_p);
					axis_q <= 2'd0;
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				cbs_pkg::ST_ACC: begin
					if (acc_q > max_q) max_q <= acc_q;
					sq_n_q <= (acc_q > max_q) ? acc_q : max_q;
					sq_res_q <= '0;
				end
				cbs_pkg::ST_SQRT: begin
					if (count_q == '0) begin
						sq_n_q <= '0;
						sq_res_q <= '0;
						sq_k_q <= '0;
					end else begin
						if (sq_n_q >= sq_try) begin
							sq_n_q <= sq_n_q - sq_try;
							sq_res_q <= (sq_res_q >> 1) + sq_bit;
						end else begin
							sq_res_q <= sq_res_q >> 1;
						end
						sq_k_q <= sq_k_q - 5'd1;
					end
				end
				cbs_pkg::ST_DONE: begin
					out_q.center_x <= (count_q == '0) ? '0 : cen_q[0];
					out_q.center_y <= (count_q == '0) ? '0 : cen_q[1];
					out_q.center_z <= (count_q == '0) ? '0 : cen_q[2];
					out_q.radius <= sq_res_q[RADIUS_W_L-1:0];
					out_q.overflowed <= drop_q;
					done_q <= 1'b1;
					for (int i = 0; i < 3; i++) sum_q[i] <= '0;
					count_q <= '0;
					drop_q <= 1'b0;
					max_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign busy = state_q != cbs_pkg::ST_IDLE;
	assign done = done_q;
	assign out_item = out_q;
endmodule

### rtl/cbs_checker.sv
// Port-level checks for the centroid bounding sphere core, bound to the top level.
// Depends on cbs_pkg.
module cbs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input cbs_pkg::in_item_t in_item
);
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_item.last_vertex |=> busy) else $error("no busy after last");
	a_plain_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !in_item.last_vertex |=> !busy) else $error("busy after vertex");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
endmodule

bind centroid_bounding_sphere_core cbs_checker u_cbs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.in_item(in_item));

### tb/centroid_bounding_sphere_checker.sv
// Scoreboard for the centroid bounding sphere core: watches the vertex and result channels,
// predicts each result from the accepted vertices and compares it as a whole item. Uses cbs_pkg.
module centroid_bounding_sphere_checker #(
	parameter int unsigned MAX_VERTICES = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cbs_pkg::in_item_t in_item,
	input logic done,
	input cbs_pkg::out_item_t out_item,
	output int fail_count,
	output int spheres_pending,
	output int spheres_checked,
	output int overflow_meshes
);
	logic signed [cbs_pkg::COORD_W-1:0] mesh_x [MAX_VERTICES];
	logic signed [cbs_pkg::COORD_W-1:0] mesh_y [MAX_VERTICES];
	logic signed [cbs_pkg::COORD_W-1:0] mesh_z [MAX_VERTICES];
	longint acc_x, acc_y, acc_z;
	int unsigned mesh_len;
	bit mesh_dropped;
	cbs_pkg::out_item_t sphere_q[$];

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	task automatic close_mesh();
		longint cx, cy, cz, dx, dy, dz;
		longint unsigned d2, best;
		cbs_pkg::out_item_t s;
		cx = 0;
		cy = 0;
		cz = 0;
		best = 0;
		if (mesh_len != 0) begin
			cx = acc_x / longint'(mesh_len);
			cy = acc_y / longint'(mesh_len);
			cz = acc_z / longint'(mesh_len);
			for (int i = 0; i < mesh_len; i++) begin
				dx = longint'(mesh_x[i]) - cx;
				dy = longint'(mesh_y[i]) - cy;
				dz = longint'(mesh_z[i]) - cz;
				d2 = dx * dx + dy * dy + dz * dz;
				if (d2 > best)
					best = d2;
			end
		end
		s.center_x = cx[cbs_pkg::COORD_W-1:0];
		s.center_y = cy[cbs_pkg::COORD_W-1:0];
		s.center_z = cz[cbs_pkg::COORD_W-1:0];
		s.radius = floor_sqrt(best) & 64'h1FF_FFFF;
		s.overflowed = mesh_dropped;
		sphere_q.push_back(s);
		if (mesh_dropped)
			overflow_meshes++;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		mesh_len = 0;
		mesh_dropped = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x = 0;
			acc_y = 0;
			acc_z = 0;
			mesh_len = 0;
			mesh_dropped = 0;
			overflow_meshes = 0;
			sphere_q.delete();
			spheres_pending = 0;
			fail_count <= 0;
			spheres_checked <= 0;
		end else begin
			if (done) begin
				if (sphere_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %p", out_item);
				end else begin
					if (out_item !== sphere_q[0]) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %p actual %p", sphere_q[0], out_item);
					end
					void'(sphere_q.pop_front());
					spheres_checked <= spheres_checked + 1;
				end
			end
			if (start && !busy) begin
				if (mesh_len < MAX_VERTICES) begin
					mesh_x[mesh_len] = in_item.x_coord;
					mesh_y[mesh_len] = in_item.y_coord;
					mesh_z[mesh_len] = in_item.z_coord;
					acc_x = acc_x + longint'(in_item.x_coord);
					acc_y = acc_y + longint'(in_item.y_coord);
					acc_z = acc_z + longint'(in_item.z_coord);
					mesh_len = mesh_len + 1;
				end else begin
					mesh_dropped = 1;
				end
				if (in_item.last_vertex)
					close_mesh();
			end
			spheres_pending = sphere_q.size();
		end
	end
endmodule

### tb/tb_centroid_bounding_sphere_core.sv
// Testbench top for centroid_bounding_sphere_core: drives meshes of vertices with random
// gaps and reports the verdict. Uses cbs_pkg and centroid_bounding_sphere_checker.
module tb_centroid_bounding_sphere_core;
	typedef logic signed [cbs_pkg::COORD_W-1:0] coord_t;

	localparam int unsigned STORE_DEPTH = 1024;
	localparam coord_t C_MAX = 24'sh7FFFFF;
	localparam coord_t C_MIN = 24'sh800000;

	logic clk;
	logic arst_n;
	logic start;
	cbs_pkg::in_item_t in_item;
	logic busy;
	logic done;
	cbs_pkg::out_item_t out_item;
	int fail_count, spheres_pending, spheres_checked, overflow_meshes;
	int vertices_sent;
	bit calm;

	centroid_bounding_sphere_core #(.MAX_VERTICES(STORE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.busy(busy), .done(done), .out_item(out_item)
	);

	centroid_bounding_sphere_checker #(.MAX_VERTICES(STORE_DEPTH)) u_scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .fail_count(fail_count),
		.spheres_pending(spheres_pending), .spheres_checked(spheres_checked),
		.overflow_meshes(overflow_meshes)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("tb_centroid_bounding_sphere_core NOT OK");
		$finish;
	end

	task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last);
		if (!calm && $urandom_range(99) < 27) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1;
		in_item <= '{x_coord: x, y_coord: y, z_coord: z, last_vertex: last};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		vertices_sent++;
	endtask

	function automatic coord_t pick_coord(int style);
		case (style)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 512)) - 24'sd256;
			default: begin
				case ($urandom_range(3))
					0: return C_MAX;
					1: return C_MIN;
					2: return 24'sd0;
					default: return -24'sd1;
				endcase
			end
		endcase
	endfunction

	task automatic send_mesh(int len, int style);
		int s;
		for (int i = 0; i < len; i++) begin
			s = (style == 3) ? $urandom_range(2) : style;
			send_vertex(pick_coord(s), pick_coord(s), pick_coord(s), i == len - 1);
		end
	endtask

	initial begin
		int len;
		arst_n = 0;
		start = 0;
		in_item = '0;
		calm = 0;
		vertices_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, truncation toward zero, full store
		send_vertex(C_MAX, C_MIN, 24'sd0, 1);
		send_vertex(C_MIN, C_MIN, C_MIN, 0);
		send_vertex(C_MAX, C_MAX, C_MAX, 1);
		send_vertex(-24'sd1, 24'sd1, -24'sd3, 0);
		send_vertex(24'sd0, 24'sd0, 24'sd0, 1);
		send_vertex(24'sd0, 24'sd0, 24'sd0, 1);
		send_mesh(STORE_DEPTH + 3, 3);

		while (vertices_sent < 1800) begin
			calm = (vertices_sent > 1300 && vertices_sent < 1600);
			len = $urandom_range(1, 16);
			send_mesh(len, $urandom_range(3));
		end
		start <= 0;

		while (spheres_pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d vertices sent, %0d spheres checked, %0d with dropped vertices",
			vertices_sent, spheres_checked, overflow_meshes);
		if (fail_count == 0)
			$display("tb_centroid_bounding_sphere_core OK");
		else
			$display("tb_centroid_bounding_sphere_core NOT OK");
		$finish;
	end
endmodule
